FILE: design/jdmsl_pkg.sv
// Shared constants, register map and slew-step function for the joystick drive mixer.
package jdmsl_pkg;

  localparam int unsigned LimW   = 7;
  localparam int unsigned StepW  = 8;
  localparam int unsigned DrvW   = 8;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned NumW   = 25;
  localparam int unsigned QuoW   = 8;
  localparam int unsigned DivInW = 15;
  localparam int unsigned MulW   = 30;

  // Targets are numerators over 127*256; rounding adds half the denominator.
  localparam logic [23:0] MixHalf = 24'd16256;
  // floor(v / 127) == (v * 16514) >> 21 for every v up to 16512; the rounded
  // magnitude divided by 256 never exceeds 16319.
  localparam logic [DivInW-1:0] Recip127 = 15'd16514;
  localparam int unsigned RecipShift = 21;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_FWD_LIMIT  = 2'd0,
    REG_BWD_LIMIT  = 2'd1,
    REG_RISE_STEP  = 2'd2,
    REG_FALL_STEP  = 2'd3
  } reg_idx_e;

  localparam logic [LimW-1:0]  FwdLimitRst = 7'd127;
  localparam logic [LimW-1:0]  BwdLimitRst = 7'd127;
  localparam logic [StepW-1:0] RiseStepRst = 8'd10;
  localparam logic [StepW-1:0] FallStepRst = 8'd10;

  // Move present drive c toward target t, never past it.
  function automatic logic signed [DrvW-1:0] slew_step(
    input logic signed [DrvW-1:0] c,
    input logic signed [DrvW-1:0] t,
    input logic [StepW-1:0]       rise,
    input logic [StepW-1:0]       fall
  );
    logic signed [10:0] cw, tw, err, adj, nv, mag, fw, rw;
    cw  = 11'(c);
    tw  = 11'(t);
    fw  = $signed({3'b000, fall});
    rw  = $signed({3'b000, rise});
    err = tw - cw;
    adj = '0;
    mag = '0;
    if (err == 11'sd0) begin
      nv = tw;
    end else begin
      if ((cw > 11'sd0 && err < 11'sd0) || (cw < 11'sd0 && err > 11'sd0)) begin
        // shrinking toward zero: snap to zero once within one fall step
        mag = (cw < 11'sd0) ? -cw : cw;
        adj = (mag <= fw) ? -cw : ((err < 11'sd0) ? -fw : fw);
      end else begin
        mag = (err < 11'sd0) ? -err : err;
        if (mag > rw) begin
          mag = rw;
        end
        adj = (err < 11'sd0) ? -mag : mag;
      end
      nv = cw + adj;
      if ((adj > 11'sd0 && nv > tw) || (adj < 11'sd0 && nv < tw)) begin
        nv = tw;
      end
    end
    return nv[DrvW-1:0];
  endfunction

endpackage

FILE: design/joystick_drive_mixer_slew_limit.sv
// Joystick differential-drive mixer with slew limiting, six-stage pipeline.
//
// Each input beat carries a joystick sample and the present left and right wheel
// drives; one output beat carries the new left and right drives. The pipeline takes
// one beat per cycle while the output side is not stalled: stage 1 multiplies the
// axes by the selected limit, stage 2 forms the quadrant mix, stage 3 takes the
// magnitude, adds the rounding half and divides by 256, stage 4 divides by 127
// through a reciprocal multiplier, stage 5 applies sign and clamps to
// [-backward_limit, forward_limit], stage 6 slews each wheel and holds the result
// for the output. Limits and steps are set through the APB port at byte addresses
// 0, 4, 8 and 12; write them only while the pipeline is empty.
module joystick_drive_mixer_slew_limit
  import jdmsl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // joy_x, joy_y, now_left, now_right
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // left_drive, right_drive
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    Q_FWD_XPOS,
    Q_FWD_XNEG,
    Q_REV_XPOS,
    Q_REV_XNEG,
    Q_SPIN
  } quad_e;

  // configuration registers
  logic [LimW-1:0]  fwd_lim_q, bwd_lim_q;
  logic [StepW-1:0] rise_q, fall_q;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_lim_q <= FwdLimitRst;
      bwd_lim_q <= BwdLimitRst;
      rise_q    <= RiseStepRst;
      fall_q    <= FallStepRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FWD_LIMIT: fwd_lim_q <= pwdata[LimW-1:0];
        REG_BWD_LIMIT: bwd_lim_q <= pwdata[LimW-1:0];
        REG_RISE_STEP: rise_q    <= pwdata[StepW-1:0];
        REG_FALL_STEP: fall_q    <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FWD_LIMIT: prdata = DataW'(fwd_lim_q);
      REG_BWD_LIMIT: prdata = DataW'(bwd_lim_q);
      REG_RISE_STEP: prdata = DataW'(rise_q);
      REG_FALL_STEP: prdata = DataW'(fall_q);
      default:       prdata = '0;
    endcase
  end

  // stage handshake: a stage loads when it is empty or its successor loads
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_q || m_axis_tready;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // stage 1: quadrant and axis products
  logic signed [DrvW-1:0]  joy_x, joy_y;
  logic [LimW-1:0]         lim_sel;
  quad_e                   quad_d, quad1_q, quad2_q;
  logic signed [ProdW-1:0] py_d, px_d, py1_q, px1_q;
  logic signed [DrvW-1:0]  cl1_q, cr1_q, cl2_q, cr2_q, cl3_q, cr3_q;
  logic signed [DrvW-1:0]  cl4_q, cr4_q, cl5_q, cr5_q;

  assign joy_x = $signed(s_axis_tdata[7:0]);
  assign joy_y = $signed(s_axis_tdata[15:8]);

  always_comb begin
    if (joy_y > 8'sd0) begin
      quad_d = (joy_x < 8'sd0) ? Q_FWD_XNEG : Q_FWD_XPOS;
    end else if (joy_y < 8'sd0) begin
      quad_d = (joy_x < 8'sd0) ? Q_REV_XNEG : Q_REV_XPOS;
    end else begin
      quad_d = Q_SPIN;
    end
    lim_sel = (joy_y < 8'sd0) ? bwd_lim_q : fwd_lim_q;
    py_d    = ProdW'(joy_y) * $signed({9'd0, lim_sel});
    px_d    = ProdW'(joy_x) * $signed({9'd0, lim_sel});
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      quad1_q <= quad_d;
      py1_q   <= py_d;
      px1_q   <= px_d;
      cl1_q   <= $signed(s_axis_tdata[23:16]);
      cr1_q   <= $signed(s_axis_tdata[31:24]);
    end
  end

  // stage 2: numerators over 127*256
  logic signed [NumW-1:0] ey, ex, y256, y254, x128, x127, nl_d, nr_d, nl2_q, nr2_q;

  always_comb begin
    ey   = NumW'(py1_q);
    ex   = NumW'(px1_q);
    y256 = ey <<< 8;
    y254 = (ey <<< 8) - (ey <<< 1);
    x128 = ex <<< 7;
    x127 = (ex <<< 7) - ex;
    case (quad1_q)
      Q_FWD_XPOS: begin nl_d = y256;        nr_d = y256 - x128; end
      Q_FWD_XNEG: begin nl_d = y256 + x127; nr_d = y256;        end
      Q_REV_XPOS: begin nl_d = y254;        nr_d = y254 + x128; end
      Q_REV_XNEG: begin nl_d = y254 - x127; nr_d = y254;        end
      default:    begin nl_d = ex <<< 8;    nr_d = -(ex <<< 8); end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      nl2_q <= nl_d;
      nr2_q <= nr_d;
      cl2_q <= cl1_q;
      cr2_q <= cr1_q;
    end
  end

  // stage 3: magnitude plus rounding half, pre-divided by 256
  logic [NumW-1:0]   ml, mr;
  logic [23:0]       al, ar;
  logic [DivInW-1:0] dl3_q, dr3_q;
  logic              sl3_q, sr3_q;

  always_comb begin
    ml = nl2_q[NumW-1] ? NumW'(-nl2_q) : NumW'(nl2_q);
    mr = nr2_q[NumW-1] ? NumW'(-nr2_q) : NumW'(nr2_q);
    al = ml[23:0] + MixHalf;
    ar = mr[23:0] + MixHalf;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      dl3_q <= al[22:8];
      dr3_q <= ar[22:8];
      sl3_q <= nl2_q[NumW-1];
      sr3_q <= nr2_q[NumW-1];
      cl3_q <= cl2_q;
      cr3_q <= cr2_q;
    end
  end

  // stage 4: divide by 127 through the reciprocal
  logic [MulW-1:0] pl, pr;
  logic [QuoW-1:0] ql4_q, qr4_q;
  logic            sl4_q, sr4_q;

  always_comb begin
    pl = MulW'(dl3_q) * MulW'(Recip127);
    pr = MulW'(dr3_q) * MulW'(Recip127);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      ql4_q <= pl[RecipShift+QuoW-1:RecipShift];
      qr4_q <= pr[RecipShift+QuoW-1:RecipShift];
      sl4_q <= sl3_q;
      sr4_q <= sr3_q;
      cl4_q <= cl3_q;
      cr4_q <= cr3_q;
    end
  end

  // stage 5: apply sign and clamp to [-backward_limit, forward_limit]
  logic signed [9:0]      tl, tr, hi, lo, tlc, trc;
  logic signed [DrvW-1:0] tl5_q, tr5_q;

  always_comb begin
    tl = sl4_q ? -$signed({2'b00, ql4_q}) : $signed({2'b00, ql4_q});
    tr = sr4_q ? -$signed({2'b00, qr4_q}) : $signed({2'b00, qr4_q});
    hi = $signed({3'b000, fwd_lim_q});
    lo = -$signed({3'b000, bwd_lim_q});
    tlc = (tl > hi) ? hi : ((tl < lo) ? lo : tl);
    trc = (tr > hi) ? hi : ((tr < lo) ? lo : tr);
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      tl5_q <= tlc[DrvW-1:0];
      tr5_q <= trc[DrvW-1:0];
      cl5_q <= cl4_q;
      cr5_q <= cr4_q;
    end
  end

  // stage 6: slew each wheel and hold for the output beat
  logic signed [DrvW-1:0] left_q, right_q;

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      left_q  <= slew_step(cl5_q, tl5_q, rise_q, fall_q);
      right_q <= slew_step(cr5_q, tr5_q, rise_q, fall_q);
    end
  end

  assign m_axis_tdata = {right_q, left_q};

endmodule
